### rtl/ryuv_pkg.sv
`default_nettype none
package ryuv_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int DIM_W  = 13;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = 25;
  localparam int PIX_W  = 8;
  localparam int DATA_W = 32;
  localparam int PADDR_W = 4;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);
  localparam logic [ADDR_W-1:0] RESET_YSIZE = ADDR_W'(640 * 480);
  localparam logic [ADDR_W-1:0] RESET_VBASE = ADDR_W'(640 * 480 + (640 * 480) / 4);

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FLIP   = 2'd2;

  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_t;

  // BT.601 integer coefficients; sums are kept in an 18-bit word
  localparam int SUM_W = 18;
  localparam int SHIFT = 8;
  localparam logic [SUM_W-1:0] COEF_Y_R = SUM_W'(66);
  localparam logic [SUM_W-1:0] COEF_Y_G = SUM_W'(129);
  localparam logic [SUM_W-1:0] COEF_Y_B = SUM_W'(25);
  localparam logic [SUM_W-1:0] COEF_U_R = SUM_W'(38);
  localparam logic [SUM_W-1:0] COEF_U_G = SUM_W'(74);
  localparam logic [SUM_W-1:0] COEF_U_B = SUM_W'(112);
  localparam logic [SUM_W-1:0] COEF_V_R = SUM_W'(112);
  localparam logic [SUM_W-1:0] COEF_V_G = SUM_W'(94);
  localparam logic [SUM_W-1:0] COEF_V_B = SUM_W'(18);
  localparam logic [SUM_W-1:0] ROUND    = SUM_W'(128);
  localparam logic [SUM_W-1:0] CHROMA_BIAS = SUM_W'(128 * 256 + 128);
  localparam logic [PIX_W-1:0] LUMA_OFFSET = PIX_W'(16);

  typedef struct packed {
    logic [DIM_W-1:0]  src_w;
    logic [DIM_W-1:0]  src_h;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic              flip;
    logic [ADDR_W-1:0] u_base;
    logic [ADDR_W-1:0] v_base;
    logic              restart;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0]  blue;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  red;
    logic              chroma;
    logic [ADDR_W-1:0] luma_addr;
    logic [ADDR_W-1:0] chroma_off;
  } item_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] conv_y(input logic [PIX_W-1:0] r,
                                              input logic [PIX_W-1:0] g,
                                              input logic [PIX_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = COEF_Y_R * SUM_W'(r) + COEF_Y_G * SUM_W'(g) + COEF_Y_B * SUM_W'(b) + ROUND;
    return PIX_W'(s >> SHIFT) + LUMA_OFFSET;
  endfunction

  // sum stays within 0..65535, so modular arithmetic gives the exact value
  function automatic logic [PIX_W-1:0] conv_u(input logic [PIX_W-1:0] r,
                                              input logic [PIX_W-1:0] g,
                                              input logic [PIX_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = CHROMA_BIAS + COEF_U_B * SUM_W'(b) - COEF_U_R * SUM_W'(r) - COEF_U_G * SUM_W'(g);
    return PIX_W'(s >> SHIFT);
  endfunction

  function automatic logic [PIX_W-1:0] conv_v(input logic [PIX_W-1:0] r,
                                              input logic [PIX_W-1:0] g,
                                              input logic [PIX_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = CHROMA_BIAS + COEF_V_R * SUM_W'(r) - COEF_V_G * SUM_W'(g) - COEF_V_B * SUM_W'(b);
    return PIX_W'(s >> SHIFT);
  endfunction

endpackage
`default_nettype wire

### rtl/ryuv_regs.sv
`default_nettype none
module ryuv_regs import ryuv_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic [DIM_W-1:0]  frame_width;
  logic [DIM_W-1:0]  frame_height;
  logic              flip;
  logic              restart;
  logic [ADDR_W-1:0] ysize;
  logic [ADDR_W-1:0] vbase;
  logic [1:0]        idx;
  logic              wr;
  logic [DIM_W-1:0]  src_w;
  logic [DIM_W-1:0]  src_h;
  logic [DIM_W-1:0]  w;
  logic [DIM_W-1:0]  h;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;

  assign src_w = clamp_dim(frame_width, DIM_W'(MAX_WIDTH));
  assign src_h = clamp_dim(frame_height, DIM_W'(MAX_HEIGHT));
  assign w     = {src_w[DIM_W-1:1], 1'b0};
  assign h     = {src_h[DIM_W-1:1], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
      flip         <= 1'b0;
      restart      <= 1'b0;
      ysize        <= RESET_YSIZE;
      vbase        <= RESET_VBASE;
    end else begin
      restart <= wr;
      // plane bases are registered and trail a write, vbase behind ysize; the front stalls only while restart is high
      ysize   <= ADDR_W'(w * h);
      vbase   <= ysize + (ysize >> 2);
      if (wr) begin
        unique case (idx)
          REG_WIDTH:  frame_width  <= pwdata[DIM_W-1:0];
          REG_HEIGHT: frame_height <= pwdata[DIM_W-1:0];
          REG_FLIP:   flip         <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = DATA_W'(frame_width);
      REG_HEIGHT: prdata = DATA_W'(frame_height);
      REG_FLIP:   prdata = DATA_W'(flip);
      default:    prdata = '0;
    endcase
  end

  assign cfg.src_w   = src_w;
  assign cfg.src_h   = src_h;
  assign cfg.w       = w;
  assign cfg.h       = h;
  assign cfg.flip    = flip;
  assign cfg.u_base  = ysize;
  assign cfg.v_base  = vbase;
  assign cfg.restart = restart;

endmodule
`default_nettype wire

### rtl/ryuv_front.sv
`default_nettype none
module ryuv_front import ryuv_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cfg_t             cfg,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [PIX_W-1:0] blue,
  input  wire logic [PIX_W-1:0] green,
  input  wire logic [PIX_W-1:0] red,
  output logic                  q_push,
  output item_t                 q_item,
  input  wire logic             q_full
);

  logic [COL_W-1:0]  column;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] luma_row_base;
  logic [ADDR_W-1:0] chroma_row_base;

  logic              acc;
  logic              in_frame;
  logic              col_end;
  logic [DIM_W-1:0]  col_inc;
  logic [DIM_W-1:0]  row_inc;
  logic [ROW_W-1:0]  row_next;
  logic [ROW_W-1:0]  base_row;
  logic [ROW_W-1:0]  orow;
  logic              load;

  assign full = cfg.restart || q_full;
  assign acc  = push && !full;

  assign col_inc = DIM_W'(column) + DIM_W'(1);
  assign row_inc = DIM_W'(row) + DIM_W'(1);
  assign col_end = col_inc >= cfg.src_w;
  assign row_next = (row_inc >= cfg.src_h) ? '0 : ROW_W'(row_inc);
  assign in_frame = (DIM_W'(column) < cfg.w) && (DIM_W'(row) < cfg.h);

  assign load     = cfg.restart || (acc && col_end);
  assign base_row = cfg.restart ? '0 : row_next;

  // output row of the row about to start; rows past the trimmed height map to 0
  always_comb begin
    if (DIM_W'(base_row) < cfg.h)
      orow = cfg.flip ? ROW_W'(cfg.h - DIM_W'(1) - DIM_W'(base_row)) : base_row;
    else
      orow = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column          <= '0;
      row             <= '0;
      luma_row_base   <= '0;
      chroma_row_base <= '0;
    end else begin
      if (cfg.restart) begin
        column <= '0;
        row    <= '0;
      end else if (acc) begin
        if (col_end) begin
          column <= '0;
          row    <= row_next;
        end else begin
          column <= COL_W'(col_inc);
        end
      end
      if (load) begin
        luma_row_base   <= ADDR_W'(orow * cfg.w);
        chroma_row_base <= ADDR_W'((orow >> 1) * (cfg.w >> 1));
      end
    end
  end

  assign q_push            = acc && in_frame;
  assign q_item.blue       = blue;
  assign q_item.green      = green;
  assign q_item.red        = red;
  assign q_item.chroma     = !row[0] && !column[0];
  assign q_item.luma_addr  = luma_row_base + ADDR_W'(column);
  assign q_item.chroma_off = chroma_row_base + ADDR_W'(column >> 1);

endmodule
`default_nettype wire

### rtl/ryuv_queue.sv
`default_nettype none
module ryuv_queue import ryuv_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t din,
  output logic       full,
  input  wire logic  pop,
  output item_t      dout,
  output logic       empty
);

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = count == (QPTR_W+1)'(QDEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + QPTR_W'(1);
      if (do_pop) rptr <= rptr + QPTR_W'(1);
      if (do_push && !do_pop) count <= count + (QPTR_W+1)'(1);
      else if (do_pop && !do_push) count <= count - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= din;
  end

endmodule
`default_nettype wire

### rtl/ryuv_back.sv
`default_nettype none
module ryuv_back import ryuv_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire item_t             q_item,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic [1:0]             plane,
  output logic [ADDR_W-1:0]      address,
  output logic [PIX_W-1:0]       value,
  output logic                   last,
  output logic                   empty,
  input  wire logic              pop
);

  typedef struct packed {
    plane_t            plane;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  value;
    logic              last;
  } res_t;

  // pixel being expanded into its results
  logic              cur_valid;
  plane_t            cur_plane;
  logic              cur_chroma;
  logic [PIX_W-1:0]  cur_y;
  logic [PIX_W-1:0]  cur_u;
  logic [PIX_W-1:0]  cur_v;
  logic [ADDR_W-1:0] cur_luma_addr;
  logic [ADDR_W-1:0] cur_u_addr;
  logic [ADDR_W-1:0] cur_v_addr;

  // two-entry result queue
  res_t              rmem [2];
  logic              rwptr;
  logic              rrptr;
  logic [1:0]        rcount;

  res_t              res;
  logic              out_pop;
  logic              room;
  logic              emit;
  logic              done;
  logic              final_res;

  assign out_pop   = pop && (rcount != 2'd0);
  assign room      = (rcount != 2'd2) || out_pop;
  assign emit      = cur_valid && room;
  assign final_res = !cur_chroma || (cur_plane == PLANE_V);
  assign done      = emit && final_res;
  assign q_pop     = !q_empty && (!cur_valid || done);

  always_comb begin
    res.plane = cur_plane;
    unique case (cur_plane)
      PLANE_Y: begin
        res.addr  = cur_luma_addr;
        res.value = cur_y;
        res.last  = !cur_chroma;
      end
      PLANE_U: begin
        res.addr  = cur_u_addr;
        res.value = cur_u;
        res.last  = 1'b0;
      end
      PLANE_V: begin
        res.addr  = cur_v_addr;
        res.value = cur_v;
        res.last  = 1'b1;
      end
      default: begin
        res.addr  = cur_luma_addr;
        res.value = cur_y;
        res.last  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_plane <= PLANE_Y;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      cur_plane <= PLANE_Y;
    end else if (done) begin
      cur_valid <= 1'b0;
    end else if (emit) begin
      cur_plane <= (cur_plane == PLANE_Y) ? PLANE_U : PLANE_V;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_chroma    <= q_item.chroma;
      cur_y         <= conv_y(q_item.red, q_item.green, q_item.blue);
      cur_u         <= conv_u(q_item.red, q_item.green, q_item.blue);
      cur_v         <= conv_v(q_item.red, q_item.green, q_item.blue);
      cur_luma_addr <= q_item.luma_addr;
      cur_u_addr    <= cfg.u_base + q_item.chroma_off;
      cur_v_addr    <= cfg.v_base + q_item.chroma_off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rwptr  <= 1'b0;
      rrptr  <= 1'b0;
      rcount <= 2'd0;
    end else begin
      if (emit) rwptr <= !rwptr;
      if (out_pop) rrptr <= !rrptr;
      if (emit && !out_pop) rcount <= rcount + 2'd1;
      else if (out_pop && !emit) rcount <= rcount - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) rmem[rwptr] <= res;
  end

  assign empty   = rcount == 2'd0;
  assign plane   = rmem[rrptr].plane;
  assign address = rmem[rrptr].addr;
  assign value   = rmem[rrptr].value;
  assign last    = rmem[rrptr].last;

endmodule
`default_nettype wire

### rtl/rgb_to_yuv420_planar.sv
`default_nettype none
// BT.601 RGB to I420 converter. Pixels enter in raster order through push/full,
// one per cycle while the internal four-entry pixel queue has room; results
// (luma, then U and V for the top-left pixel of each 2x2 block) leave through
// empty/pop, one per cycle when popped, with the I420 byte address of each
// sample. The single result port sets the pace: a luma-only pixel yields one
// result, a chroma-carrying pixel three, 1.5 per pixel over a frame. Results
// pass the pixel queue, conversion registers and result queue. Any register
// write restarts the frame and holds full high for the following cycle while
// the row bases reload; write configuration only with no pixels in flight.
module rgb_to_yuv420_planar import ryuv_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [PIX_W-1:0]   blue,
  input  wire logic [PIX_W-1:0]   green,
  input  wire logic [PIX_W-1:0]   red,
  output logic                    empty,
  input  wire logic               pop,
  output logic      [1:0]         plane,
  output logic      [ADDR_W-1:0]  address,
  output logic      [PIX_W-1:0]   value,
  output logic                    last
);

  cfg_t  cfg;
  item_t f_item;
  item_t b_item;
  logic  f_push;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;

  ryuv_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ryuv_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .push   (push),
    .full   (full),
    .blue   (blue),
    .green  (green),
    .red    (red),
    .q_push (f_push),
    .q_item (f_item),
    .q_full (q_full)
  );

  ryuv_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   (f_item),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (b_item),
    .empty (q_empty)
  );

  ryuv_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_item  (b_item),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .plane   (plane),
    .address (address),
    .value   (value),
    .last    (last),
    .empty   (empty),
    .pop     (pop)
  );

endmodule
`default_nettype wire
